// ===== rtl/core/dspv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dspv_pkg: shared types and constants for the date string parser
// Transaction payload structs, character codes and small calendar helpers.
// ----------------------------------------------------------------------------
package dspv_pkg;

    // Input transaction: one ASCII character plus end-of-string marker
    typedef struct packed {
        logic [7:0] char_code;
        logic       last;
    } t_dspv_in;

    // Output transaction: parsed fields and calendar check
    typedef struct packed {
        logic [15:0] day_value;
        logic [15:0] month_value;
        logic [15:0] year_value;
        logic        date_valid;
    } t_dspv_out;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    // Output field ceiling
    localparam logic [15:0] OUT_MAX = 16'hFFFF;

    // Field indexes
    localparam logic [1:0] FIELD_DAY   = 2'd0;
    localparam logic [1:0] FIELD_MONTH = 2'd1;
    localparam logic [1:0] FIELD_YEAR  = 2'd2;
    localparam logic [1:0] FIELD_EXTRA = 2'd3;

    // Month numbers with 30 days, and February
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_NOV = 4'd11;

    // Residue mod 25 of a value below 256 (reciprocal multiply, exact here)
    function automatic logic [4:0] mod25(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  qx25;
        prod = 16'(v) * 16'd41;
        q    = prod[14:10];
        qx25 = 8'(q) * 8'd25;
        return 5'(v - qx25);
    endfunction

    // Days in a month (month already known to be 1..12)
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        len = 5'd31;
        if (m == MON_FEB) begin
            len = leap ? 5'd29 : 5'd28;
        end else if (m == MON_APR || m == MON_JUN || m == MON_SEP || m == MON_NOV) begin
            len = 5'd30;
        end
        return len;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/date_string_parse_validate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// date_string_parse_validate: day.month.year text parser and date checker
// Streams ASCII characters, parses up to three atoi-style fields and checks
// the result against the Gregorian calendar.
// ----------------------------------------------------------------------------
// The block takes one character per cycle, back to back, on the input
// channel; '.' or a zero byte closes a field. A character marked last
// produces one output transaction, registered in the cycle after that
// character is accepted: day, month and year magnitudes (saturated at 65535)
// plus a validity flag. All parse state returns to reset after it. The
// digit accumulate is one multiply-by-ten and add per cycle; the year's
// residue mod 25 is tracked alongside it so the leap test needs no divider.
// Non-last characters are accepted even while a result waits in the output
// register; a last character waits only until that register drains.
// ----------------------------------------------------------------------------
module date_string_parse_validate #(
    parameter int FIELD_WIDTH = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_ready,
    input  dspv_pkg::t_dspv_in   i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output dspv_pkg::t_dspv_out  o_out_data
);
    import dspv_pkg::*;

    localparam int                     EXT_W     = (FIELD_WIDTH > 16) ? FIELD_WIDTH : 16;
    localparam logic [FIELD_WIDTH-1:0] FIELD_MAX = {FIELD_WIDTH{1'b1}};
    localparam logic [4:0]             SAT_MOD25 =
        5'(((64'd1 << FIELD_WIDTH) - 64'd1) % 64'd25);

    // Parse state
    logic [1:0]             r_field_count, n_field_count;
    logic [2:0]             r_fields_seen, n_fields_seen;
    logic [FIELD_WIDTH-1:0] r_acc, n_acc;
    logic [4:0]             r_acc_mod25, n_acc_mod25;
    logic                   r_started, n_started;
    logic                   r_stopped, n_stopped;
    logic                   r_neg, n_neg;
    logic [FIELD_WIDTH-1:0] r_day_mag, n_day_mag;
    logic [FIELD_WIDTH-1:0] r_mon_mag, n_mon_mag;
    logic [FIELD_WIDTH-1:0] r_year_mag, n_year_mag;
    logic                   r_day_neg, n_day_neg;
    logic                   r_mon_neg, n_mon_neg;
    logic                   r_year_neg, n_year_neg;
    logic [4:0]             r_year_mod25, n_year_mod25;

    // Output register
    logic      r_out_valid;
    t_dspv_out r_out_data;

    logic                   in_fire;
    logic [7:0]             ch;
    logic                   is_term, is_digit, is_space, is_sign;
    logic [3:0]             digit;
    logic [FIELD_WIDTH+3:0] acc_x10;
    logic [7:0]             res_x10;
    logic                   leap, month_ok, date_ok;
    t_dspv_out              res;

    assign in_fire    = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready || !i_in_data.last;

    // Character classes
    assign ch       = i_in_data.char_code;
    assign is_term  = (ch == CHAR_DOT) || (ch == CHAR_NUL);
    assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign is_space = (ch == CHAR_SPACE) || ((ch >= CHAR_TAB) && (ch <= CHAR_CR));
    assign is_sign  = (ch == CHAR_PLUS) || (ch == CHAR_MINUS);
    assign digit    = 4'(ch - CHAR_ZERO);

    // Multiply-by-ten and add, with residue mod 25 kept in step
    assign acc_x10 = ({4'd0, r_acc} << 3) + ({4'd0, r_acc} << 1) + (FIELD_WIDTH+4)'(digit);
    assign res_x10 = (8'(r_acc_mod25) << 3) + (8'(r_acc_mod25) << 1) + 8'(digit);

    // Next parse state
    always_comb begin
        n_field_count = r_field_count;
        n_fields_seen = r_fields_seen;
        n_acc         = r_acc;
        n_acc_mod25   = r_acc_mod25;
        n_started     = r_started;
        n_stopped     = r_stopped;
        n_neg         = r_neg;
        n_day_mag     = r_day_mag;
        n_mon_mag     = r_mon_mag;
        n_year_mag    = r_year_mag;
        n_day_neg     = r_day_neg;
        n_mon_neg     = r_mon_neg;
        n_year_neg    = r_year_neg;
        n_year_mod25  = r_year_mod25;
        if (is_term) begin
            // Close the current field
            case (r_field_count)
                FIELD_DAY: begin
                    n_day_mag = r_acc;
                    n_day_neg = r_neg;
                end
                FIELD_MONTH: begin
                    n_mon_mag = r_acc;
                    n_mon_neg = r_neg;
                end
                FIELD_YEAR: begin
                    n_year_mag   = r_acc;
                    n_year_neg   = r_neg;
                    n_year_mod25 = r_acc_mod25;
                end
                default: begin
                end
            endcase
            if (r_field_count != FIELD_EXTRA) begin
                n_field_count = r_field_count + 2'd1;
            end
            if (r_fields_seen != 3'd7) begin
                n_fields_seen = r_fields_seen + 3'd1;
            end
            n_acc       = '0;
            n_acc_mod25 = '0;
            n_started   = 1'b0;
            n_stopped   = 1'b0;
            n_neg       = 1'b0;
        end else if (!r_stopped) begin
            if (is_digit) begin
                if (acc_x10[FIELD_WIDTH+3:FIELD_WIDTH] != 4'd0) begin
                    n_acc       = FIELD_MAX;
                    n_acc_mod25 = SAT_MOD25;
                end else begin
                    n_acc       = acc_x10[FIELD_WIDTH-1:0];
                    n_acc_mod25 = mod25(res_x10);
                end
                n_started = 1'b1;
            end else if (!r_started) begin
                if (is_sign) begin
                    n_neg     = (ch == CHAR_MINUS);
                    n_started = 1'b1;
                end else if (!is_space) begin
                    n_stopped = 1'b1;
                end
            end else begin
                n_stopped = 1'b1;
            end
        end
    end

    // Calendar check on the fields as they stand after this character
    always_comb begin
        logic div4, div16, div25;
        logic [EXT_W-1:0] day_x, mon_x, year_x;
        div4     = (n_year_mag[1:0] == 2'd0);
        div16    = (n_year_mag[3:0] == 4'd0);
        div25    = (n_year_mod25 == 5'd0);
        leap     = (div4 && !div25) || (div16 && div25);
        month_ok = (n_mon_mag >= FIELD_WIDTH'(1)) && (n_mon_mag <= FIELD_WIDTH'(12));
        date_ok  = (n_fields_seen >= 3'd3)
                && !(n_day_neg && (n_day_mag != '0))
                && !(n_mon_neg && (n_mon_mag != '0))
                && !(n_year_neg && (n_year_mag != '0))
                && (n_year_mag != '0)
                && (n_day_mag != '0)
                && month_ok
                && (n_day_mag <= FIELD_WIDTH'(month_len(n_mon_mag[3:0], leap)));
        day_x  = EXT_W'(n_day_mag);
        mon_x  = EXT_W'(n_mon_mag);
        year_x = EXT_W'(n_year_mag);
        res.day_value   = (day_x > EXT_W'(OUT_MAX)) ? OUT_MAX : day_x[15:0];
        res.month_value = (mon_x > EXT_W'(OUT_MAX)) ? OUT_MAX : mon_x[15:0];
        res.year_value  = (year_x > EXT_W'(OUT_MAX)) ? OUT_MAX : year_x[15:0];
        res.date_valid  = date_ok;
    end

    // Parse state registers; a last character restarts the parser
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (in_fire && i_in_data.last)) begin
            r_field_count <= FIELD_DAY;
            r_fields_seen <= '0;
            r_acc         <= '0;
            r_acc_mod25   <= '0;
            r_started     <= 1'b0;
            r_stopped     <= 1'b0;
            r_neg         <= 1'b0;
            r_day_mag     <= '0;
            r_mon_mag     <= '0;
            r_year_mag    <= '0;
            r_day_neg     <= 1'b0;
            r_mon_neg     <= 1'b0;
            r_year_neg    <= 1'b0;
            r_year_mod25  <= '0;
        end else if (in_fire) begin
            r_field_count <= n_field_count;
            r_fields_seen <= n_fields_seen;
            r_acc         <= n_acc;
            r_acc_mod25   <= n_acc_mod25;
            r_started     <= n_started;
            r_stopped     <= n_stopped;
            r_neg         <= n_neg;
            r_day_mag     <= n_day_mag;
            r_mon_mag     <= n_mon_mag;
            r_year_mag    <= n_year_mag;
            r_day_neg     <= n_day_neg;
            r_mon_neg     <= n_mon_neg;
            r_year_neg    <= n_year_neg;
            r_year_mod25  <= n_year_mod25;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && i_in_data.last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_in_data.last) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for date_string_parse_validate
// Streams day.month.year character sequences into the parser, mirrors the
// atoi-style field parse and Gregorian check in a behavioral predictor, and
// compares every output transaction field by field against it.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dspv_pkg::*;

    localparam int         FIELD_BITS   = 16;
    localparam longint     FIELD_CEIL   = (longint'(1) << FIELD_BITS) - 1;
    localparam int         CHAR_TARGET  = 1900;
    localparam int         STALL_LIMIT  = 3000;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         HOLD_CYCLES  = 400;
    localparam logic [7:0] CHAR_JUNK_LO = 8'h41;
    localparam logic [7:0] CHAR_JUNK_HI = 8'h7A;

    // Pending input transaction; a sync entry waits until all dates are out
    typedef struct {
        t_dspv_in item;
        bit       sync;
    } t_pending;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_dspv_in  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_dspv_out o_out_data;

    date_string_parse_validate #(
        .FIELD_WIDTH (FIELD_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #10 i_clk = ~i_clk;

    // Parser mirror state
    int        fld_index;
    longint    fld_acc;
    bit        fld_started;
    bit        fld_stopped;
    bit        fld_neg;
    longint    date_mag [3];
    bit        date_neg [3];
    int        closed_fields;
    t_dspv_out date_expect_q [$];

    // Stimulus and handshake bookkeeping
    t_pending  pending_q [$];
    int        char_total   = 0;
    bit        sync_next    = 1'b0;
    logic      in_taken     = 1'b0;
    int        results_seen = 0;
    int        fail_count   = 0;
    int        quiet_cycles = 0;
    int        burst_left   = 0;
    int        gap_left     = 0;
    int        hold_left    = 0;
    int        holds_done   = 0;
    int        rx_mode      = 0;
    int        rx_mode_left = 0;
    int        rx_phase     = 0;

    function automatic void clear_field();
        fld_acc     = 0;
        fld_started = 1'b0;
        fld_stopped = 1'b0;
        fld_neg     = 1'b0;
    endfunction

    function automatic void reset_parser();
        fld_index     = 0;
        closed_fields = 0;
        clear_field();
        for (int i = 0; i < 3; i++) begin
            date_mag[i] = 0;
            date_neg[i] = 1'b0;
        end
    endfunction

    // Advance the parser mirror by one character; queue a date on last
    function automatic void parse_date_char(t_dspv_in it);
        logic [7:0] c;
        bit         is_digit;
        bit         is_space;
        bit         leap;
        bit         ok;
        longint     sum;
        longint     mlen;
        t_dspv_out  res;
        c = it.char_code;
        if (c == CHAR_DOT || c == CHAR_NUL) begin
            if (fld_index < 3) begin
                date_mag[fld_index] = fld_acc;
                date_neg[fld_index] = fld_neg;
                fld_index++;
            end
            if (closed_fields < 7) closed_fields++;
            clear_field();
        end else if (!fld_stopped) begin
            is_digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
            is_space = (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR));
            if (is_digit) begin
                sum         = fld_acc * 10 + longint'(c - CHAR_ZERO);
                fld_acc     = (sum > FIELD_CEIL) ? FIELD_CEIL : sum;
                fld_started = 1'b1;
            end else if (!fld_started) begin
                if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                    fld_neg     = (c == CHAR_MINUS);
                    fld_started = 1'b1;
                end else if (!is_space) begin
                    fld_stopped = 1'b1;
                end
            end else begin
                fld_stopped = 1'b1;
            end
        end
        if (!it.last) return;

        // Gregorian check on day/month/year
        leap = ((date_mag[2] % 4 == 0) && (date_mag[2] % 100 != 0))
            || (date_mag[2] % 400 == 0);
        if (date_mag[1] == MON_FEB) begin
            mlen = leap ? 29 : 28;
        end else if (date_mag[1] == MON_APR || date_mag[1] == MON_JUN
                  || date_mag[1] == MON_SEP || date_mag[1] == MON_NOV) begin
            mlen = 30;
        end else if (date_mag[1] >= 1 && date_mag[1] <= 12) begin
            mlen = 31;
        end else begin
            mlen = 0;
        end
        ok = (closed_fields >= 3);
        for (int i = 0; i < 3; i++) begin
            if (date_neg[i] && date_mag[i] != 0) ok = 1'b0;
        end
        ok = ok && date_mag[2] >= 1 && date_mag[0] >= 1 && date_mag[0] <= mlen;
        res.day_value   = (date_mag[0] > OUT_MAX) ? OUT_MAX : date_mag[0][15:0];
        res.month_value = (date_mag[1] > OUT_MAX) ? OUT_MAX : date_mag[1][15:0];
        res.year_value  = (date_mag[2] > OUT_MAX) ? OUT_MAX : date_mag[2][15:0];
        res.date_valid  = ok;
        date_expect_q.push_back(res);
        reset_parser();
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // Monitor: feeds accepted characters to the mirror, checks results
    always @(posedge i_clk) begin : monitor_proc
        t_dspv_out want;
        in_taken <= i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                parse_date_char(i_in_data);
            end
            if (o_out_valid && i_out_ready) begin
                results_seen <= results_seen + 1;
                if (date_expect_q.size() == 0) begin
                    $error("output transaction with no expected date: day %0d month %0d",
                        o_out_data.day_value, o_out_data.month_value);
                    fail_count++;
                end else begin
                    want = date_expect_q.pop_front();
                    check_field("day_value", longint'(want.day_value),
                        longint'(o_out_data.day_value));
                    check_field("month_value", longint'(want.month_value),
                        longint'(o_out_data.month_value));
                    check_field("year_value", longint'(want.year_value),
                        longint'(o_out_data.year_value));
                    check_field("date_valid", longint'(want.date_valid),
                        longint'(o_out_data.date_valid));
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge i_clk) begin : watchdog_proc
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Driver: bursts of characters with random gaps
    always @(negedge i_clk) begin : feed_proc
        logic     drive_valid;
        t_pending entry;
        drive_valid = i_in_valid;
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            drive_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_q.size() > 0
                      && !(pending_q[0].sync && date_expect_q.size() > 0)) begin
                entry = pending_q.pop_front();
                i_in_data  <= entry.item;
                drive_valid = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
        i_in_valid <= drive_valid;
    end

    // Receiver: stall patterns plus two long hold-offs
    always @(negedge i_clk) begin : drain_proc
        logic rdy;
        rx_phase++;
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else if ((holds_done == 0 && results_seen >= 40)
                  || (holds_done == 1 && results_seen >= 100)) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            rdy       = 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(8, 64);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0:       rdy = 1'b1;
                1:       rdy = 1'($urandom_range(0, 1));
                2:       rdy = ($urandom_range(0, 3) == 0);
                default: rdy = (rx_phase % 3 != 0);
            endcase
        end
        i_out_ready <= rdy;
    end

    task automatic push_char(logic [7:0] c, bit last);
        t_pending entry;
        entry.item.char_code = c;
        entry.item.last      = last;
        entry.sync           = sync_next;
        sync_next            = 1'b0;
        pending_q.push_back(entry);
        char_total++;
    endtask

    // Text with last on its final character
    task automatic push_text(string s, bit last);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i], last && (i == s.len() - 1));
        end
    endtask

    task automatic push_space();
        int k;
        k = $urandom_range(9, 14);
        push_char((k == 14) ? CHAR_SPACE : 8'(k), 1'b0);
    endtask

    // One field: optional lead-in, sign, digits, junk tail, terminator
    task automatic put_field(longint v, bit last);
        int lead;
        if ($urandom_range(0, 5) == 0) begin
            lead = $urandom_range(1, 2);
            repeat (lead) push_space();
        end
        case ($urandom_range(0, 19))
            0, 1:    push_char(CHAR_PLUS, 1'b0);
            2:       push_char(CHAR_MINUS, 1'b0);
            default: ;
        endcase
        if ($urandom_range(0, 7) == 0) push_char(CHAR_ZERO, 1'b0);
        push_text($sformatf("%0d", v), 1'b0);
        if ($urandom_range(0, 11) == 0) begin
            if ($urandom_range(0, 1) == 0) push_space();
            else push_char(8'($urandom_range(CHAR_JUNK_LO, CHAR_JUNK_HI)), 1'b0);
            push_text($sformatf("%0d", $urandom_range(0, 99)), 1'b0);
        end
        push_char(($urandom_range(0, 7) == 0) ? CHAR_NUL : CHAR_DOT, last);
    endtask

    initial begin : stim_proc
        int     strings;
        int     n;
        longint d;
        longint m;
        longint y;
        logic [7:0] c;
        reset_parser();

        // Directed: leap rules, lead-in and signs, saturation, missing and
        // extra fields, empty fields, stopped digits, zero-byte terminators
        push_text("29.2.2000.", 1'b1);
        push_text("29.2.1900.", 1'b1);
        push_text(" \t-0.+12.99999.", 1'b1);
        push_text("31.4", 1'b1);
        push_text("1.-3.7.8.9", 1'b1);
        push_text("...", 1'b1);
        push_text("5x9.12 3.2024", 1'b0);
        push_char(CHAR_NUL, 1'b1);
        push_text("28.2.2023", 1'b0);
        push_char(CHAR_NUL, 1'b1);
        push_char(8'hFF, 1'b0);
        push_text(".31.12.1.", 1'b1);

        // Random: mostly well-formed dates, some broken strings and noise
        strings = 0;
        while (char_total < CHAR_TARGET) begin
            strings++;
            if (strings == 30 || strings == 180) sync_next = 1'b1;
            case ($urandom_range(0, 9))
                0: begin
                    n = $urandom_range(1, 12);
                    repeat (n) begin
                        case ($urandom_range(0, 3))
                            1:       c = 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
                            2:       c = CHAR_DOT;
                            default: c = 8'($urandom_range(0, 255));
                        endcase
                        push_char(c, $urandom_range(0, 3) == 0);
                    end
                end
                default: begin
                    case ($urandom_range(0, 5))
                        0:       y = longint'($urandom_range(0, 163)) * 400;
                        1:       y = longint'($urandom_range(1, 655)) * 100;
                        2:       y = longint'($urandom_range(0, 16383)) * 4;
                        3:       y = longint'($urandom_range(0, 65535));
                        4:       y = longint'($urandom_range(1, 3000));
                        default: y = longint'($urandom_range(65536, 999999));
                    endcase
                    m = ($urandom_range(0, 7) == 0) ? longint'($urandom_range(0, 99))
                                                    : longint'($urandom_range(1, 12));
                    case ($urandom_range(0, 5))
                        0:       d = longint'($urandom_range(0, 40));
                        1:       d = longint'($urandom_range(28, 31));
                        default: d = longint'($urandom_range(1, 31));
                    endcase
                    put_field(d, 1'b0);
                    put_field(m, 1'b0);
                    case ($urandom_range(0, 9))
                        0: begin
                            put_field(y, 1'b0);
                            put_field(longint'($urandom_range(0, 99)), 1'b1);
                        end
                        1: begin
                            put_field(y, 1'b0);
                            push_text($sformatf("%0d", $urandom_range(0, 999)), 1'b1);
                        end
                        2: push_text($sformatf("%0d", y), 1'b1);
                        default: put_field(y, 1'b1);
                    endcase
                end
            endcase
        end
        // Close any noise string still open
        push_char(CHAR_DOT, 1'b1);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() > 0 || i_in_valid || date_expect_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && date_expect_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== date_string_parse_validate.f =====
rtl/core/dspv_pkg.sv
rtl/core/date_string_parse_validate.sv
test/testbench.sv
